// File: rtl/hbs_pkg.sv
// Shared widths, codes and constants of the heightmap bilinear sampler.
`timescale 1ns / 1ps
package hbs_pkg;

  // Configuration port.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     MAP_SIZE_RESET = 9'd256;

  // Item commands.
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Field widths.
  localparam int COORD_W  = 8;
  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 16;
  localparam int HEIGHT_W = 23;

  // Output scaling: heights carry 16 fractional bits before the divide by three.
  localparam int SCALE_BITS = 16;
  localparam int SCALED_W   = SAMPLE_W + SCALE_BITS;
  // floor(t / 3) == (t * RECIP3) >> RECIP3_SHIFT for every t below 2**SCALED_W.
  localparam logic [SCALED_W-1:0] RECIP3       = 24'hAAAAAB;
  localparam int                  RECIP3_SHIFT = SCALED_W + 1;

  // Defaults of the top-level parameters.
  localparam int MAX_SIDE_DEFAULT  = 256;
  localparam int FRAC_BITS_DEFAULT = 8;

endpackage

// File: rtl/hbs_in_if.sv
// Input channel of the sampler: store and query items.
`timescale 1ns / 1ps
interface hbs_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [hbs_pkg::COORD_W-1:0]       col;
  logic [hbs_pkg::COORD_W-1:0]       row;
  logic [hbs_pkg::SAMPLE_W-1:0]      sample;
  logic [hbs_pkg::POS_W-1:0]         pos_x;
  logic [hbs_pkg::POS_W-1:0]         pos_z;

  modport source (output valid, cmd, col, row, sample, pos_x, pos_z, input ready);
  modport sink   (input valid, cmd, col, row, sample, pos_x, pos_z, output ready);
endinterface

// File: rtl/hbs_out_if.sv
// Result channel of the sampler: interpolated heights.
`timescale 1ns / 1ps
interface hbs_out_if;
  logic                              valid;
  logic                              ready;
  logic [hbs_pkg::HEIGHT_W-1:0]      height;
  logic                              out_of_range;

  modport source (output valid, height, out_of_range, input ready);
  modport sink   (input valid, height, out_of_range, output ready);
endinterface

// File: rtl/hbs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module hbs_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/heightmap_bilinear_sampler.sv
// Heightmap bilinear sampler: four parity banks of samples and a four-stage query pipeline.
// Queries pass stages 1-3 and the output stage; one item is taken each cycle unless stalled.
// The rate is set by the four banks, which deliver all four corners of a cell in one read.
// A store item is written at its transfer and is seen by any query transferred after it.
// Reset clears the pipeline and sets both map sizes to 256; the sample store is not cleared.
`timescale 1ns / 1ps
module heightmap_bilinear_sampler #(
  parameter int MAX_SIDE  = hbs_pkg::MAX_SIDE_DEFAULT,
  parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hbs_in_if.sink                          in_ch,
  hbs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hbs_pkg::CFG_W-1:0]       cfg_data
);

  localparam int POS_W    = hbs_pkg::POS_W;
  localparam int CEIL_W   = POS_W - FRAC_BITS + 1;
  localparam int SIZE_W   = $clog2(MAX_SIDE + 1);
  localparam int CMP_A    = (CEIL_W > hbs_pkg::CFG_W) ? CEIL_W : hbs_pkg::CFG_W;
  localparam int CMP_B    = (SIZE_W > hbs_pkg::COORD_W) ? SIZE_W : hbs_pkg::COORD_W;
  localparam int CMP_W    = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;
  localparam int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int HALF     = (MAX_SIDE + 1) / 2;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BANK_AW  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int W_W      = FRAC_BITS + 1;
  localparam int A_W      = hbs_pkg::SAMPLE_W + FRAC_BITS;
  localparam int V_W      = hbs_pkg::SAMPLE_W + 2 * FRAC_BITS;
  localparam int SHL      = (2 * FRAC_BITS > hbs_pkg::SCALE_BITS) ?
                            0 : hbs_pkg::SCALE_BITS - 2 * FRAC_BITS;
  localparam int SHR      = (2 * FRAC_BITS > hbs_pkg::SCALE_BITS) ?
                            2 * FRAC_BITS - hbs_pkg::SCALE_BITS : 0;
  localparam int VS_W     = V_W + SHL;
  localparam int SW       = hbs_pkg::SCALED_W;
  localparam int SAMPLE_W = hbs_pkg::SAMPLE_W;

  localparam logic [W_W-1:0]   ONE       = W_W'(1) << FRAC_BITS;
  localparam logic [CMP_W-1:0] SIDE_CMP  = CMP_W'(MAX_SIDE);
  localparam logic [BANK_AW-1:0] HALF_A  = BANK_AW'(HALF);

  // Configuration registers.
  logic [hbs_pkg::CFG_W-1:0] map_width_r, map_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= hbs_pkg::MAP_SIZE_RESET;
      map_height_r <= hbs_pkg::MAP_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hbs_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_data;
        hbs_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage moves when it is empty or the next one moves.
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_en, s2_en, s3_en, out_en;
  logic in_xfer;

  assign out_en  = !out_v_r || out_ch.ready;
  assign s3_en   = !s3_v_r || out_en;
  assign s2_en   = !s2_v_r || s3_en;
  assign s1_en   = !s1_v_r || s2_en;
  assign in_ch.ready = s1_en;
  assign in_xfer = in_ch.valid && s1_en;

  // Position split into ceiling corner and weights.
  logic [FRAC_BITS-1:0] frac_x, frac_z;
  logic [CEIL_W-1:0]    cx, cz;
  logic [W_W-1:0]       ex, ez, wx, wz;
  logic [CMP_W-1:0]     w_eff, h_eff;
  logic                 q_oor;

  always_comb begin
    frac_x = in_ch.pos_x[FRAC_BITS-1:0];
    frac_z = in_ch.pos_z[FRAC_BITS-1:0];
    cx = CEIL_W'(in_ch.pos_x[POS_W-1:FRAC_BITS]) + CEIL_W'(frac_x != '0);
    cz = CEIL_W'(in_ch.pos_z[POS_W-1:FRAC_BITS]) + CEIL_W'(frac_z != '0);
    ex = (frac_x == '0) ? '0 : ONE - W_W'(frac_x);
    ez = (frac_z == '0) ? '0 : ONE - W_W'(frac_z);
    wx = ONE - ex;
    wz = ONE - ez;
    w_eff = (CMP_W'(map_width_r) > SIDE_CMP) ? SIDE_CMP : CMP_W'(map_width_r);
    h_eff = (CMP_W'(map_height_r) > SIDE_CMP) ? SIDE_CMP : CMP_W'(map_height_r);
    q_oor = (cx == '0) || (CMP_W'(cx) >= w_eff) || (cz == '0) || (CMP_W'(cz) >= h_eff);
  end

  // Banks split by column parity (bit 0) and row parity (bit 1) of the bank number.
  // The even column of a cell is at half index cx/2 and the odd one at (cx-1)/2.
  logic [IDX_W-1:0]    cx_i, cz_i, cxm_i, czm_i;
  logic [IDX_W-1:0]    col_i, row_i;
  logic                store_ok;
  logic [BANK_AW-1:0]  wr_addr;
  logic [SAMPLE_W-1:0] bank_rd [4];

  always_comb begin
    cx_i  = IDX_W'(cx);
    cz_i  = IDX_W'(cz);
    cxm_i = IDX_W'(cx - CEIL_W'(1));
    czm_i = IDX_W'(cz - CEIL_W'(1));
    col_i = IDX_W'(in_ch.col);
    row_i = IDX_W'(in_ch.row);
    store_ok = (CMP_W'(in_ch.col) < SIDE_CMP) && (CMP_W'(in_ch.row) < SIDE_CMP);
    wr_addr = BANK_AW'(row_i >> 1) * HALF_A + BANK_AW'(col_i >> 1);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PC = ((b % 2) != 0);
    localparam logic PR = ((b / 2) != 0);
    logic [IDX_W-1:0]   ch, rh;
    logic [BANK_AW-1:0] rd_addr;
    logic               wr_en;

    assign ch      = PC ? (cxm_i >> 1) : (cx_i >> 1);
    assign rh      = PR ? (czm_i >> 1) : (cz_i >> 1);
    assign rd_addr = BANK_AW'(rh) * HALF_A + BANK_AW'(ch);
    assign wr_en   = in_xfer && (in_ch.cmd == hbs_pkg::CMD_STORE) && store_ok &&
                     (in_ch.col[0] == PC) && (in_ch.row[0] == PR);

    hbs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (in_ch.sample),
      .re    (s1_en),
      .raddr (rd_addr),
      .rdata (bank_rd[b])
    );
  end

  // Stage 1: bank data arrives alongside the query's weights.
  logic [W_W-1:0] s1_ex_r, s1_wx_r, s1_ez_r, s1_wz_r;
  logic           s1_px_r, s1_pz_r, s1_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_xfer && (in_ch.cmd == hbs_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_ex_r  <= ex;
      s1_wx_r  <= wx;
      s1_ez_r  <= ez;
      s1_wz_r  <= wz;
      s1_px_r  <= cx[0];
      s1_pz_r  <= cz[0];
      s1_oor_r <= q_oor;
    end
  end

  // Stage 2: interpolate along x for the upper and lower rows of the cell.
  logic [SAMPLE_W-1:0] c_lo_lo, c_hi_lo, c_lo_hi, c_hi_hi;
  logic [A_W-1:0]      a_nxt, b_nxt, s2_a_r, s2_b_r;
  logic [W_W-1:0]      s2_ez_r, s2_wz_r;
  logic                s2_oor_r;

  always_comb begin
    c_lo_lo = bank_rd[{!s1_pz_r, !s1_px_r}];
    c_hi_lo = bank_rd[{!s1_pz_r,  s1_px_r}];
    c_lo_hi = bank_rd[{ s1_pz_r, !s1_px_r}];
    c_hi_hi = bank_rd[{ s1_pz_r,  s1_px_r}];
    a_nxt = A_W'(c_lo_lo) * A_W'(s1_ex_r) + A_W'(c_hi_lo) * A_W'(s1_wx_r);
    b_nxt = A_W'(c_lo_hi) * A_W'(s1_ex_r) + A_W'(c_hi_hi) * A_W'(s1_wx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_a_r   <= a_nxt;
      s2_b_r   <= b_nxt;
      s2_ez_r  <= s1_ez_r;
      s2_wz_r  <= s1_wz_r;
      s2_oor_r <= s1_oor_r;
    end
  end

  // Stage 3: interpolate along z.
  logic [V_W-1:0] v_nxt, s3_v_data_r;
  logic           s3_oor_r;

  assign v_nxt = V_W'(s2_a_r) * V_W'(s2_ez_r) + V_W'(s2_b_r) * V_W'(s2_wz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_v_data_r <= v_nxt;
      s3_oor_r    <= s2_oor_r;
    end
  end

  // Output stage: align to 16 fractional bits, then divide by three through the reciprocal.
  logic [VS_W-1:0]                   v_shl;
  logic [SW-1:0]                     scaled;
  logic [2*SW-1:0]                   quot_prod;
  logic [hbs_pkg::HEIGHT_W-1:0]      height_nxt, height_r;
  logic                              oor_r;

  always_comb begin
    v_shl      = VS_W'(s3_v_data_r) << SHL;
    scaled     = SW'(v_shl >> SHR);
    quot_prod  = (2*SW)'(scaled) * (2*SW)'(hbs_pkg::RECIP3);
    height_nxt = s3_oor_r ? '0 : quot_prod[hbs_pkg::RECIP3_SHIFT +: hbs_pkg::HEIGHT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      height_r <= height_nxt;
      oor_r    <= s3_oor_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.height       = height_r;
  assign out_ch.out_of_range = oor_r;

  // A stalled in-map query in stage 1 must keep the bank data it was given.
  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_oor_r && !s2_en) |=> $stable(bank_rd[0]) && $stable(bank_rd[1]) &&
                                        $stable(bank_rd[2]) && $stable(bank_rd[3]))
    else $error("bank read data changed under a stalled query");

  // Input is refused only when the whole pipeline is full.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && s3_v_r && out_v_r))
    else $error("input refused with a free pipeline stage");

  // An out-of-map result always reports zero height.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && oor_r) |-> (height_r == '0))
    else $error("out-of-range result with nonzero height");

endmodule

// File: tb/sv/heightmap_bilinear_sampler_tb.sv
// Self-checking testbench of the heightmap bilinear sampler with random stores and queries.
`timescale 1ns / 1ps
module heightmap_bilinear_sampler_tb;
  import hbs_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEFAULT;
  localparam int SIDE       = MAX_SIDE_DEFAULT;
  localparam int ONE        = 1 << FRAC;
  localparam int SETTLE     = 10;
  localparam int LONG_HOLD  = 400;
  localparam int HOLD_AFTER = 150;
  localparam int NUM_PHASES = 10;

  typedef struct packed {
    logic                cmd;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_z;
  } hbs_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                out_of_range;
  } height_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  hbs_in_if  in_ch();
  hbs_out_if out_ch();

  heightmap_bilinear_sampler uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted block state, and the generator's record of which cells hold a sample.
  logic [SAMPLE_W-1:0] hmap [0:SIDE*SIDE-1];
  bit                  cell_set [0:SIDE*SIDE-1];
  logic [CFG_W-1:0]    map_w_reg = MAP_SIZE_RESET;
  logic [CFG_W-1:0]    map_h_reg = MAP_SIZE_RESET;

  hbs_item_t   pending_items[$];
  height_res_t expected_heights[$];
  hbs_item_t   offer;
  bit          in_fire;
  bit          calm;
  int          mismatch_count;
  int          results_seen;
  int          items_made;

  int unsigned phase_w   [NUM_PHASES] = '{256, 2, 2, 256, 0, 300, 511, 17, 0, 256};
  int unsigned phase_h   [NUM_PHASES] = '{256, 2, 256, 2, 1, 511, 257, 131, 0, 256};
  int          phase_len [NUM_PHASES] = '{190, 190, 190, 190, 60, 190, 190, 190, 190, 200};

  function automatic int unsigned eff_side(logic [CFG_W-1:0] r);
    return (r > SIDE) ? SIDE : r;
  endfunction

  function automatic int unsigned ceil_of(logic [POS_W-1:0] p);
    return int'(p >> FRAC) + int'(p[FRAC-1:0] != 0);
  endfunction

  function automatic int unsigned weight_of(logic [POS_W-1:0] p);
    return (p[FRAC-1:0] == 0) ? 0 : ONE - p[FRAC-1:0];
  endfunction

  function automatic bit query_in_map(int unsigned cx, int unsigned cz);
    return cx >= 1 && cx + 1 <= eff_side(map_w_reg) && cz >= 1 && cz + 1 <= eff_side(map_h_reg);
  endfunction

  // A position whose ceiling is cx, with a random weight.
  function automatic logic [POS_W-1:0] pos_in_cell(int unsigned cx);
    if (cx == 0) return '0;
    return POS_W'(cx * ONE - $urandom_range(cx >= SIDE ? 1 : 0, ONE - 1));
  endfunction

  function automatic void push_store(int unsigned c, int unsigned r, int unsigned s);
    hbs_item_t it;
    it = '0;
    it.cmd = CMD_STORE;
    it.col = COORD_W'(c);
    it.row = COORD_W'(r);
    it.sample = SAMPLE_W'(s);
    pending_items.push_back(it);
    cell_set[r * SIDE + c] = 1'b1;
    items_made++;
  endfunction

  function automatic void push_query(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
    hbs_item_t it;
    it = '0;
    it.cmd = CMD_QUERY;
    it.col = COORD_W'($urandom_range(0, SIDE - 1));
    it.row = COORD_W'($urandom_range(0, SIDE - 1));
    it.sample = SAMPLE_W'($urandom_range(0, 255));
    it.pos_x = px;
    it.pos_z = pz;
    pending_items.push_back(it);
    items_made++;
  endfunction

  // Updates the predicted store, or works out the height a query must return.
  function automatic void apply_item(hbs_item_t it);
    int unsigned     cx, cz, ex, ez, top, bot;
    longint unsigned v;
    height_res_t     r;
    if (it.cmd == CMD_STORE) begin
      hmap[it.row * SIDE + it.col] = it.sample;
      return;
    end
    cx = ceil_of(it.pos_x);
    cz = ceil_of(it.pos_z);
    r.height = '0;
    r.out_of_range = 1'b1;
    if (query_in_map(cx, cz)) begin
      ex = weight_of(it.pos_x);
      ez = weight_of(it.pos_z);
      top = hmap[(cz - 1) * SIDE + cx - 1] * ex + hmap[(cz - 1) * SIDE + cx] * (ONE - ex);
      bot = hmap[cz * SIDE + cx - 1] * ex + hmap[cz * SIDE + cx] * (ONE - ex);
      v = longint'(top) * ez + longint'(bot) * (ONE - ez);
      if (2 * FRAC > SCALE_BITS) v = v / (3 << (2 * FRAC - SCALE_BITS));
      else v = (v << (SCALE_BITS - 2 * FRAC)) / 3;
      r.height = v[HEIGHT_W-1:0];
      r.out_of_range = 1'b0;
    end
    expected_heights.push_back(r);
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] height check failed: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic write_map_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAP_WIDTH) map_w_reg = val;
    else map_h_reg = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_ch.valid || expected_heights.size() > 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Transfers are observed here, before the block's registers update.
  always @(posedge clk) begin
    height_res_t want;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) apply_item(offer);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_heights.size() == 0) begin
        flag_mismatch($sformatf("unexpected result height %0d", out_ch.height));
      end else begin
        want = expected_heights.pop_front();
        if (out_ch.height !== want.height)
          flag_mismatch($sformatf("height %0d, expected %0d", out_ch.height, want.height));
        if (out_ch.out_of_range !== want.out_of_range)
          flag_mismatch($sformatf("out_of_range %b, expected %b",
                                  out_ch.out_of_range, want.out_of_range));
      end
    end
  end

  int in_gap, in_run;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // The current item waits for its transfer.
    end else if (in_gap > 0) begin
      in_gap--;
      in_ch.valid <= 1'b0;
    end else if (!calm && in_run == 0 && $urandom_range(0, 5) == 0) begin
      in_gap = $urandom_range(1, 17) - 1;
      in_run = $urandom_range(0, 60);
      in_ch.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      if (in_run > 0) in_run--;
      offer = pending_items.pop_front();
      in_ch.cmd    <= offer.cmd;
      in_ch.col    <= offer.col;
      in_ch.row    <= offer.row;
      in_ch.sample <= offer.sample;
      in_ch.pos_x  <= offer.pos_x;
      in_ch.pos_z  <= offer.pos_z;
      in_ch.valid  <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  int  out_gap, out_run, hold_left;
  bit  long_hold_done;

  // Once enough results have come, one long stall backs the pipeline up to the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && out_run == 0 && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_run = $urandom_range(0, 60);
      out_ch.ready <= 1'b0;
    end else begin
      if (out_run > 0) out_run--;
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned w, h, cx, cz, ox, oz, c, r, s, fill;
    int          goal, pick;
    logic [POS_W-1:0] px, pz;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_MAP_WIDTH;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_STORE;
    in_ch.col    = '0;
    in_ch.row    = '0;
    in_ch.sample = '0;
    in_ch.pos_x  = '0;
    in_ch.pos_z  = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset map size: both map corners, weights zero and
    // near one, the largest height, and queries just off both column edges and the first-row edge.
    push_store(0, 0, 8'h00);
    push_store(1, 0, 8'hFF);
    push_store(0, 1, 8'h80);
    push_store(1, 1, 8'h01);
    push_store(254, 254, 8'hFF);
    push_store(255, 254, 8'hFF);
    push_store(254, 255, 8'hFF);
    push_store(255, 255, 8'hFF);
    push_query(16'h0100, 16'h0100);
    push_query(16'h0001, 16'h0001);
    push_query(16'h00FF, 16'h0080);
    push_query(16'hFF00, 16'hFF00);
    push_query(16'hFE01, 16'hFE01);
    push_query(16'hFFFF, 16'h0100);
    push_query(16'h0000, 16'h0100);
    push_query(16'h0100, 16'h0000);
    push_store(1, 1, 8'hAA);
    push_query(16'h0100, 16'h0100);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph == 8) begin
        phase_w[ph] = $urandom_range(2, SIDE);
        phase_h[ph] = $urandom_range(2, SIDE);
      end
      write_map_reg(REG_MAP_WIDTH, CFG_W'(phase_w[ph]));
      write_map_reg(REG_MAP_HEIGHT, CFG_W'(phase_h[ph]));
      calm = (ph == NUM_PHASES - 1);
      w = eff_side(map_w_reg);
      h = eff_side(map_h_reg);
      goal = items_made + phase_len[ph];
      while (items_made < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Fill the corners of one cell, then query inside it.
          if (w < 2) cx = $urandom_range(1, SIDE - 1);
          else if ($urandom_range(0, 3) == 0) cx = $urandom_range(0, 1) ? 1 : w - 1;
          else cx = $urandom_range(1, w - 1);
          if (h < 2) cz = $urandom_range(1, SIDE - 1);
          else if ($urandom_range(0, 3) == 0) cz = $urandom_range(0, 1) ? 1 : h - 1;
          else cz = $urandom_range(1, h - 1);
          fill = $urandom_range(0, 3);
          for (int k = 0; k < 4; k++) begin
            c = cx - 1 + k % 2;
            r = cz - 1 + k / 2;
            s = (fill == 0) ? 0 : (fill == 1) ? 255 : $urandom_range(0, 255);
            if (!cell_set[r * SIDE + c] || $urandom_range(0, 1)) push_store(c, r, s);
          end
          repeat ($urandom_range(1, 4)) push_query(pos_in_cell(cx), pos_in_cell(cz));
        end else if (pick < 70) begin
          push_store($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                     $urandom_range(0, 255));
        end else if (pick < 88) begin
          // Any position, dropped if it would read a cell that holds nothing yet.
          px = POS_W'($urandom_range(0, 16'hFFFF));
          pz = POS_W'($urandom_range(0, 16'hFFFF));
          cx = ceil_of(px);
          cz = ceil_of(pz);
          if (!query_in_map(cx, cz) ||
              (cell_set[(cz - 1) * SIDE + cx - 1] && cell_set[(cz - 1) * SIDE + cx] &&
               cell_set[cz * SIDE + cx - 1] && cell_set[cz * SIDE + cx]))
            push_query(px, pz);
        end else begin
          ox = $urandom_range(0, 1) ? 0 : $urandom_range(w, SIDE);
          oz = $urandom_range(0, 1) ? 0 : $urandom_range(h, SIDE);
          cx = $urandom_range(1, SIDE - 1);
          cz = $urandom_range(1, SIDE - 1);
          case ($urandom_range(0, 2))
            0: cx = ox;
            1: cz = oz;
            default: begin
              cx = ox;
              cz = oz;
            end
          endcase
          push_query(pos_in_cell(cx), pos_in_cell(cz));
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("heightmap_bilinear_sampler: match");
    end else begin
      $display("heightmap_bilinear_sampler: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("heightmap_bilinear_sampler: mismatch");
    $finish;
  end

endmodule
